// ----- design/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants for the sparse CSR transpose core
// Sizes, field widths, operation and result codes, controller interface.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int MAX_NNZ  = 4096;
    localparam int VALUE_W  = 32;

    localparam int COL_W   = 10;                   // a_col / out_col field
    localparam int ROW_W   = 10;                   // a_row field
    localparam int CFG_W   = 11;                   // num_cols / num_rows
    localparam int OROW_W  = 11;                   // out_row field
    localparam int CNT_W   = 13;                   // counts and offsets
    localparam int SLOT_W  = $clog2(MAX_NNZ);      // slot address
    localparam int HCOL_W  = $clog2(MAX_COLS);     // column head address
    localparam int LINK_W  = SLOT_W + 1;           // {valid, slot}
    localparam int CFG_IDX_W = 8;

    localparam int IN_DATA_W  = 56;                // a_row, a_col, elem_value
    localparam int OUT_DATA_W = 72;                // out_row .. overflow

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 8'd1;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_PULL    = 2'd1,
        FUNC_RESTART = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_OFFSET = 2'd0,
        KIND_ELEM   = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_LOAD = 2'd0,
        PH_EMIT = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_LOAD  = 2'd2,
        ST_PULL  = 2'd3
    } t_state;

    typedef struct packed {
        logic clear_step;   // write one empty column head
        logic load_start;   // latch nonzero, read its column head
        logic load_drop;    // reject load, set overflow
        logic load_commit;  // write slot and new column head
        logic pull_start;   // read head and pointer targets
        logic pull_exec;    // form result into output register
        logic restart;      // clear counts, start clearing pass
    } t_cmd;

    typedef struct packed {
        logic load_ok;
        logic out_free;
        logic clear_last;
    } t_status;

endpackage

// ----- design/sct_ctrl.sv -----
// ----------------------------------------------------------------------------
// sct_ctrl: sequencing controller
// Steps the clearing pass, load read-modify-write and pull fetch/emit.
// ----------------------------------------------------------------------------
module sct_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_func,
    input  sct_pkg::t_status i_status,
    output logic             o_in_ready,
    output sct_pkg::t_cmd    o_cmd
);

    sct_pkg::t_state r_state;
    sct_pkg::t_state n_state;
    sct_pkg::t_func  w_func;

    assign w_func = sct_pkg::t_func'(i_func);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sct_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sct_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = sct_pkg::ST_IDLE;
            end
            sct_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_func)
                        sct_pkg::FUNC_LOAD: begin
                            if (i_status.load_ok) n_state = sct_pkg::ST_LOAD;
                        end
                        sct_pkg::FUNC_PULL:    n_state = sct_pkg::ST_PULL;
                        sct_pkg::FUNC_RESTART: n_state = sct_pkg::ST_CLEAR;
                        default:               n_state = sct_pkg::ST_IDLE;
                    endcase
                end
            end
            sct_pkg::ST_LOAD: n_state = sct_pkg::ST_IDLE;
            sct_pkg::ST_PULL: begin
                if (i_status.out_free) n_state = sct_pkg::ST_IDLE;
            end
            default: n_state = sct_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sct_pkg::ST_CLEAR: o_cmd.clear_step = 1'b1;
            sct_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (w_func)
                        sct_pkg::FUNC_LOAD: begin
                            o_cmd.load_start = i_status.load_ok;
                            o_cmd.load_drop  = !i_status.load_ok;
                        end
                        sct_pkg::FUNC_PULL:    o_cmd.pull_start = 1'b1;
                        sct_pkg::FUNC_RESTART: o_cmd.restart    = 1'b1;
                        default: ;
                    endcase
                end
            end
            sct_pkg::ST_LOAD: o_cmd.load_commit = 1'b1;
            sct_pkg::ST_PULL: o_cmd.pull_exec   = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- design/sct_datapath.sv -----
// ----------------------------------------------------------------------------
// sct_datapath: list memories, counters and result register
// Column heads, per-slot link/row/value stores, config and output register.
// ----------------------------------------------------------------------------
module sct_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sct_pkg::t_cmd                       i_cmd,
    output sct_pkg::t_status                    o_status,
    input  logic [sct_pkg::ROW_W-1:0]           i_a_row,
    input  logic [sct_pkg::COL_W-1:0]           i_a_col,
    input  logic [sct_pkg::VALUE_W-1:0]         i_elem_value,
    input  logic                                i_cfg_we,
    input  logic [sct_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sct_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [1:0]                          o_kind,
    output logic [sct_pkg::OROW_W-1:0]          o_out_row,
    output logic [sct_pkg::COL_W-1:0]           o_out_col,
    output logic [sct_pkg::VALUE_W-1:0]         o_out_value,
    output logic [sct_pkg::CNT_W-1:0]           o_offset,
    output logic                                o_overflow,
    output logic                                o_last
);

    // memories
    logic [sct_pkg::LINK_W-1:0]  head_mem  [sct_pkg::MAX_COLS];
    logic [sct_pkg::LINK_W-1:0]  link_mem  [sct_pkg::MAX_NNZ];
    logic [sct_pkg::ROW_W-1:0]   row_mem   [sct_pkg::MAX_NNZ];
    logic [sct_pkg::VALUE_W-1:0] value_mem [sct_pkg::MAX_NNZ];

    logic [sct_pkg::LINK_W-1:0]  r_head_rd;
    logic [sct_pkg::LINK_W-1:0]  r_link_rd;
    logic [sct_pkg::ROW_W-1:0]   r_row_rd;
    logic [sct_pkg::VALUE_W-1:0] r_value_rd;

    logic [sct_pkg::CFG_W-1:0]   r_num_cols;
    logic [sct_pkg::CFG_W-1:0]   r_num_rows;
    logic [sct_pkg::HCOL_W-1:0]  r_clr_addr;
    logic [sct_pkg::CNT_W-1:0]   r_elem_cnt;
    logic [sct_pkg::OROW_W-1:0]  r_emit_col;
    logic [sct_pkg::SLOT_W-1:0]  r_emit_ptr;
    logic                        r_ptr_valid;
    logic [sct_pkg::CNT_W-1:0]   r_fill_cnt;
    sct_pkg::t_phase             r_phase;
    logic                        r_ovf;

    // latched load
    logic [sct_pkg::ROW_W-1:0]   r_ld_row;
    logic [sct_pkg::COL_W-1:0]   r_ld_col;
    logic [sct_pkg::VALUE_W-1:0] r_ld_value;

    logic                        r_out_valid;
    logic [1:0]                  r_kind;
    logic [sct_pkg::OROW_W-1:0]  r_out_row;
    logic [sct_pkg::COL_W-1:0]   r_out_col;
    logic [sct_pkg::VALUE_W-1:0] r_out_value;
    logic [sct_pkg::CNT_W-1:0]   r_offset;
    logic                        r_out_ovf;
    logic                        r_last;

    logic [sct_pkg::CFG_W-1:0]   w_cols_eff;
    logic [sct_pkg::CFG_W-1:0]   w_rows_eff;
    logic [sct_pkg::HCOL_W-1:0]  w_head_raddr;
    logic [sct_pkg::SLOT_W-1:0]  w_slot;
    logic                        w_emit_elem;
    logic                        w_emit_hdr;

    assign w_cols_eff = (r_num_cols > sct_pkg::CFG_W'(sct_pkg::MAX_COLS))
                      ? sct_pkg::CFG_W'(sct_pkg::MAX_COLS) : r_num_cols;
    assign w_rows_eff = (r_num_rows > sct_pkg::CFG_W'(sct_pkg::MAX_ROWS))
                      ? sct_pkg::CFG_W'(sct_pkg::MAX_ROWS) : r_num_rows;
    assign w_slot     = r_elem_cnt[sct_pkg::SLOT_W-1:0];

    assign o_status.load_ok    = (r_phase == sct_pkg::PH_LOAD)
                              && (sct_pkg::CFG_W'(i_a_row) < w_rows_eff)
                              && (sct_pkg::CFG_W'(i_a_col) < w_cols_eff)
                              && (r_elem_cnt < sct_pkg::CNT_W'(sct_pkg::MAX_NNZ));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.clear_last = (r_clr_addr == sct_pkg::HCOL_W'(sct_pkg::MAX_COLS - 1));

    // a pull in the loading phase always starts at column 0
    assign w_head_raddr = i_cmd.load_start ? sct_pkg::HCOL_W'(i_a_col)
                        : (r_phase == sct_pkg::PH_LOAD) ? '0
                        : r_emit_col[sct_pkg::HCOL_W-1:0];

    assign w_emit_elem = (r_phase != sct_pkg::PH_DONE) && r_ptr_valid;
    assign w_emit_hdr  = (r_phase != sct_pkg::PH_DONE) && !r_ptr_valid
                      && (r_emit_col < w_cols_eff);

    // column heads: clearing pass, head update on commit, one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            head_mem[r_clr_addr] <= '0;
        end else if (i_cmd.load_commit) begin
            head_mem[sct_pkg::HCOL_W'(r_ld_col)] <= {1'b1, w_slot};
        end
        if (i_cmd.load_start || i_cmd.pull_start) begin
            r_head_rd <= head_mem[w_head_raddr];
        end
    end

    // slot stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_commit) begin
            link_mem[w_slot]  <= r_head_rd;
            row_mem[w_slot]   <= r_ld_row;
            value_mem[w_slot] <= r_ld_value;
        end
        if (i_cmd.pull_start) begin
            r_link_rd  <= link_mem[r_emit_ptr];
            r_row_rd   <= row_mem[r_emit_ptr];
            r_value_rd <= value_mem[r_emit_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_ld_row   <= i_a_row;
            r_ld_col   <= i_a_col;
            r_ld_value <= i_elem_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= sct_pkg::CFG_W'(1024);
            r_num_rows <= sct_pkg::CFG_W'(1024);
        end else if (i_cfg_we) begin
            if (i_cfg_index == sct_pkg::CFG_NUM_COLS) r_num_cols <= i_cfg_data;
            if (i_cfg_index == sct_pkg::CFG_NUM_ROWS) r_num_rows <= i_cfg_data;
        end
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_clr_addr  <= '0;
            r_elem_cnt  <= '0;
            r_emit_col  <= '0;
            r_emit_ptr  <= '0;
            r_ptr_valid <= 1'b0;
            r_fill_cnt  <= '0;
            r_phase     <= sct_pkg::PH_LOAD;
            r_ovf       <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load_drop) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.load_commit) begin
                r_elem_cnt <= r_elem_cnt + 1'b1;
            end
            if (i_cmd.pull_start && r_phase == sct_pkg::PH_LOAD) begin
                r_phase     <= sct_pkg::PH_EMIT;
                r_emit_col  <= '0;
                r_ptr_valid <= 1'b0;
                r_fill_cnt  <= '0;
            end
            if (i_cmd.pull_exec) begin
                if (w_emit_elem) begin
                    r_fill_cnt  <= r_fill_cnt + 1'b1;
                    r_ptr_valid <= r_link_rd[sct_pkg::LINK_W-1];
                    r_emit_ptr  <= r_link_rd[sct_pkg::SLOT_W-1:0];
                end else if (w_emit_hdr) begin
                    r_ptr_valid <= r_head_rd[sct_pkg::LINK_W-1];
                    r_emit_ptr  <= r_head_rd[sct_pkg::SLOT_W-1:0];
                    r_emit_col  <= r_emit_col + 1'b1;
                end else if (r_phase != sct_pkg::PH_DONE) begin
                    r_ptr_valid <= 1'b0;
                    r_phase     <= sct_pkg::PH_DONE;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pull_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pull_exec) begin
            r_out_ovf <= r_ovf;
            if (r_phase == sct_pkg::PH_DONE) begin
                r_kind      <= sct_pkg::KIND_DONE;
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_value <= '0;
                r_offset    <= '0;
                r_last      <= 1'b0;
            end else if (w_emit_elem) begin
                r_kind      <= sct_pkg::KIND_ELEM;
                r_out_row   <= r_emit_col - 1'b1;
                r_out_col   <= r_row_rd;
                r_out_value <= r_value_rd;
                r_offset    <= r_fill_cnt;
                r_last      <= 1'b0;
            end else if (w_emit_hdr) begin
                r_kind      <= sct_pkg::KIND_OFFSET;
                r_out_row   <= r_emit_col;
                r_out_col   <= '0;
                r_out_value <= '0;
                r_offset    <= r_fill_cnt;
                r_last      <= 1'b0;
            end else begin
                // closing offset
                r_kind      <= sct_pkg::KIND_OFFSET;
                r_out_row   <= w_cols_eff;
                r_out_col   <= '0;
                r_out_value <= '0;
                r_offset    <= r_elem_cnt;
                r_last      <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_offset    = r_offset;
    assign o_overflow  = r_out_ovf;
    assign o_last      = r_last;

endmodule

// ----- design/sparse_csr_transpose_core.sv -----
// ----------------------------------------------------------------------------
// sparse_csr_transpose_core: CSR matrix transpose by column linked lists
// Loads gather nonzeros per column; pulls stream the transposed matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction, selected by s_axis_tuser:
//   load a nonzero, pull the next result, or restart. Loads must arrive rows
//   last to first, ascending within a row. Each pull gives one m_axis
//   transaction: a row-start offset, a transposed nonzero, or done; the
//   closing offset (equal to the nonzero count) is marked by m_axis_tlast.
//   Loads that are out of range, beyond 4096 slots or after the first pull
//   are dropped and set the sticky overflow bit carried in every result.
//   The cfg channel writes num_cols (index 0) and num_rows (index 1); it is
//   always ready and is meant to be used while the core is idle.
// Timing:
//   A load is a column-head read then a head/slot write; a pull is a
//   synchronous read of the head and the list pointer, then the output
//   register, which drives m_axis. A dropped load or an unused code is
//   handled in the idle state alone, with s_axis_tready kept high.
//   Reset and each restart start a clearing pass over all 1024 column heads,
//   one per cycle, with s_axis_tready low throughout the pass.
//   If m_axis is stalled, loads still proceed; a pull waits in its output
//   step until the output register is free, holding s_axis_tready low.
// ----------------------------------------------------------------------------
module sparse_csr_transpose_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: a_row[9:0], a_col[19:10], elem_value[51:20], zero pad
    input  logic [sct_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: out_row[10:0], out_col[20:11], out_value[52:21], offset[65:53],
    //        overflow[66], zero pad
    output logic [sct_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sct_pkg::CFG_W-1:0]        i_cfg_data
);

    sct_pkg::t_cmd    w_cmd;
    sct_pkg::t_status w_status;

    logic [sct_pkg::OROW_W-1:0]  w_out_row;
    logic [sct_pkg::COL_W-1:0]   w_out_col;
    logic [sct_pkg::VALUE_W-1:0] w_out_value;
    logic [sct_pkg::CNT_W-1:0]   w_offset;
    logic                        w_overflow;

    assign o_cfg_ready = 1'b1;

    sct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    sct_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_a_row      (s_axis_tdata[9:0]),
        .i_a_col      (s_axis_tdata[19:10]),
        .i_elem_value (s_axis_tdata[51:20]),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_kind       (m_axis_tuser),
        .o_out_row    (w_out_row),
        .o_out_col    (w_out_col),
        .o_out_value  (w_out_value),
        .o_offset     (w_offset),
        .o_overflow   (w_overflow),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, w_overflow, w_offset, w_out_value, w_out_col, w_out_row};

    // restart always enters the clearing pass
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == sct_pkg::FUNC_RESTART
        |=> !s_axis_tready)
        else $error("restart did not start clearing pass");

    a_last_is_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == sct_pkg::KIND_OFFSET)
        else $error("tlast on a non-offset result");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == sct_pkg::KIND_DONE
        |-> m_axis_tdata[65:0] == '0 && !m_axis_tlast)
        else $error("done result carries data");

    // a new result only comes from the output step of a pull, with s_axis_tready low
    a_result_from_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a pull in progress");

endmodule

// ----- dv/sct_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sct_checker: transposed-stream predictor and scoreboard
// Watches the op, result and register channels of the transpose core. It
// keeps its own column lists and output cursor, queues the result that each
// accepted pull should give, and checks every result transaction field by
// field against the oldest queued one.
// ----------------------------------------------------------------------------
module sct_checker
    import sct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    input  logic [1:0]             i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_DATA_W-1:0]  i_m_tdata,
    input  logic [1:0]             i_m_tuser,
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int OCOL_LSB = OROW_W;
    localparam int OVAL_LSB = OCOL_LSB + COL_W;
    localparam int OFFS_LSB = OVAL_LSB + VALUE_W;
    localparam int OVF_BIT  = OFFS_LSB + CNT_W;

    typedef struct {
        t_kind               kind;
        logic [OROW_W-1:0]   row;
        logic [COL_W-1:0]    col;
        logic [VALUE_W-1:0]  value;
        logic [CNT_W-1:0]    offset;
        logic                overflow;
        logic                last;
    } t_transposed;

    t_transposed pending_transposed[$];

    // register copies
    logic [CFG_W-1:0] num_cols_q;
    logic [CFG_W-1:0] num_rows_q;

    // column lists, newest slot at the head
    logic [SLOT_W-1:0]  col_head     [MAX_COLS];
    bit                 col_head_ok  [MAX_COLS];
    logic [SLOT_W-1:0]  slot_link    [MAX_NNZ];
    bit                 slot_link_ok [MAX_NNZ];
    logic [ROW_W-1:0]   slot_row     [MAX_NNZ];
    logic [VALUE_W-1:0] slot_value   [MAX_NNZ];

    int unsigned        nnz_count;
    int unsigned        emit_col;
    logic [SLOT_W-1:0]  emit_ptr;
    bit                 emit_ptr_ok;
    logic [CNT_W-1:0]   out_pos;
    t_phase             stream_phase;
    bit                 dropped;
    int                 fail_cnt;

    assign o_fail_count = fail_cnt;

    function automatic int unsigned cols_limit();
        return (num_cols_q > MAX_COLS) ? MAX_COLS : num_cols_q;
    endfunction

    function automatic int unsigned rows_limit();
        return (num_rows_q > MAX_ROWS) ? MAX_ROWS : num_rows_q;
    endfunction

    function automatic void restart_lists();
        int i;
        for (i = 0; i < MAX_COLS; i++) col_head_ok[i] = 1'b0;
        nnz_count    = 0;
        emit_col     = 0;
        emit_ptr     = '0;
        emit_ptr_ok  = 1'b0;
        out_pos      = '0;
        stream_phase = PH_LOAD;
        dropped      = 1'b0;
    endfunction

    function automatic void gather_nonzero(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                           logic [VALUE_W-1:0] value);
        if (stream_phase != PH_LOAD || row >= rows_limit() || col >= cols_limit() ||
            nnz_count >= MAX_NNZ) begin
            dropped = 1'b1;
            return;
        end
        slot_row[nnz_count]     = row;
        slot_value[nnz_count]   = value;
        slot_link[nnz_count]    = col_head[col];
        slot_link_ok[nnz_count] = col_head_ok[col];
        col_head[col]           = nnz_count[SLOT_W-1:0];
        col_head_ok[col]        = 1'b1;
        nnz_count++;
    endfunction

    function automatic t_transposed emit_next();
        t_transposed r;
        logic [SLOT_W-1:0] p;
        r.kind     = KIND_OFFSET;
        r.row      = '0;
        r.col      = '0;
        r.value    = '0;
        r.offset   = '0;
        r.last     = 1'b0;
        if (stream_phase == PH_LOAD) begin
            stream_phase = PH_EMIT;
            emit_col     = 0;
            emit_ptr_ok  = 1'b0;
            out_pos      = '0;
        end
        if (stream_phase == PH_DONE) begin
            r.kind = KIND_DONE;
        end else if (emit_ptr_ok) begin
            p           = emit_ptr;
            r.kind      = KIND_ELEM;
            r.row       = OROW_W'(emit_col - 1);
            r.col       = slot_row[p];
            r.value     = slot_value[p];
            r.offset    = out_pos;
            out_pos     = out_pos + 1'b1;
            emit_ptr_ok = slot_link_ok[p];
            emit_ptr    = slot_link[p];
        end else if (emit_col < cols_limit()) begin
            r.row       = OROW_W'(emit_col);
            r.offset    = out_pos;
            emit_ptr_ok = col_head_ok[emit_col];
            emit_ptr    = col_head[emit_col];
            emit_col++;
        end else begin
            // closing offset: nonzero count, flagged last
            r.row        = OROW_W'(cols_limit());
            r.offset     = CNT_W'(nnz_count);
            r.last       = 1'b1;
            emit_ptr_ok  = 1'b0;
            stream_phase = PH_DONE;
        end
        r.overflow = dropped;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_transposed want;
        if (!i_rst_n) begin
            num_cols_q = CFG_W'(MAX_COLS);
            num_rows_q = CFG_W'(MAX_ROWS);
            restart_lists();
            pending_transposed.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_transposed.size() == 0) begin
                    $error("result transaction with no pull outstanding");
                    fail_cnt++;
                end else begin
                    want = pending_transposed.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("out_row", want.row, i_m_tdata[0 +: OROW_W]);
                    check_field("out_col", want.col, i_m_tdata[OCOL_LSB +: COL_W]);
                    check_field("out_value", want.value, i_m_tdata[OVAL_LSB +: VALUE_W]);
                    check_field("offset", want.offset, i_m_tdata[OFFS_LSB +: CNT_W]);
                    check_field("overflow", want.overflow, i_m_tdata[OVF_BIT]);
                    check_field("last", want.last, i_m_tlast);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_NUM_COLS) num_cols_q = i_cfg_data;
                else if (i_cfg_index == CFG_NUM_ROWS) num_rows_q = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    FUNC_LOAD:    gather_nonzero(i_s_tdata[0 +: ROW_W],
                                                 i_s_tdata[ROW_W +: COL_W],
                                                 i_s_tdata[ROW_W + COL_W +: VALUE_W]);
                    FUNC_PULL:    pending_transposed.push_back(emit_next());
                    FUNC_RESTART: restart_lists();
                    default: ;
                endcase
            end
        end
        o_pending = pending_transposed.size();
    end

endmodule

// ----- dv/tb_sparse_csr_transpose_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_csr_transpose_core: testbench for the sparse CSR transpose core
// Loads column-gathered nonzeros in row-descending order, pulls the
// transposed stream and lets sct_checker predict and compare every result.
// Directed corner cases first, then randomized matrices under several
// sender/receiver idle mixes, with a full slot store and a long output stall.
// ----------------------------------------------------------------------------
module tb_sparse_csr_transpose_core;
    import sct_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 475;

    localparam logic [1:0]           FUNC_NONE     = 2'd3;   // not decoded by the core
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int items_sent = 0;
    int cycle_cnt  = 0;
    int fail_count;
    int pending;

    sparse_csr_transpose_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sct_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_op(input logic [1:0] func, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(IN_DATA_W - ROW_W - COL_W - VALUE_W){1'b0}}, value, col, row};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (func != FUNC_NONE) items_sent++;
    endtask

    task automatic pull_n(input int n);
        repeat (n) send_op(FUNC_PULL, $urandom, $urandom, $urandom);
    endtask

    // every queued result out, then let a trailing load finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ignored op, random load, or a load outside the configured matrix
    task automatic noise_item(input int ceff, input int reff);
        case ($urandom_range(2))
            0: send_op(FUNC_NONE, $urandom, $urandom, $urandom);
            1: send_op(FUNC_LOAD, $urandom, $urandom, $urandom);
            default: begin
                if (reff < MAX_ROWS)
                    send_op(FUNC_LOAD, $urandom_range(reff, 1023), $urandom, $urandom);
                else if (ceff < MAX_COLS)
                    send_op(FUNC_LOAD, $urandom, $urandom_range(ceff, 1023), $urandom);
                else
                    send_op(FUNC_LOAD, $urandom, $urandom, $urandom);
            end
        endcase
    endtask

    // 4096 accepted loads, two more dropped, then the start of the stream
    task automatic fill_store();
        drain();
        write_reg(CFG_NUM_COLS, 11'd8);
        write_reg(CFG_NUM_ROWS, 11'd1024);
        send_op(FUNC_RESTART, $urandom, $urandom, $urandom);
        repeat (MAX_NNZ + 2) send_op(FUNC_LOAD, $urandom, $urandom_range(0, 7), $urandom);
        pull_n(12);
    endtask

    // One matrix: configure, restart, load rows last to first, pull the stream.
    task automatic run_session(input int cols, input int rows, input int nnz_goal,
                               input bit may_break, input int hold);
        int ceff, reff, sent, pulls, r, c, k, j, i, step, event_at, event_kind;
        ceff = (cols > MAX_COLS) ? MAX_COLS : cols;
        reff = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        drain();
        write_reg(CFG_NUM_COLS, cols);
        write_reg(CFG_NUM_ROWS, rows);
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? CFG_IDX_SPARE : CFG_IDX_TOP, $urandom);
        send_op(FUNC_RESTART, $urandom, $urandom, $urandom);
        sent = 0;
        step = 3 * reff / (nnz_goal + 1) + 1;
        r = reff - 1;
        if ($urandom_range(3) == 0) noise_item(ceff, reff);
        while (r >= 0 && sent < nnz_goal) begin
            k = $urandom_range(0, 3);
            c = (ceff > 1) ? $urandom_range(0, ceff / 2) : 0;
            for (j = 0; j < k && c < ceff && sent < nnz_goal; j++) begin
                send_op(FUNC_LOAD, r, c, $urandom);
                sent++;
                c += $urandom_range(1, (ceff > 8) ? ceff / 4 : 2);
            end
            if ($urandom_range(11) == 0) noise_item(ceff, reff);
            r -= $urandom_range(1, step);
        end
        pulls = ceff + sent + 1 + $urandom_range(0, 2);
        if (may_break && $urandom_range(4) == 0) pulls = $urandom_range(1, pulls);
        event_at   = $urandom_range(0, pulls - 1);
        event_kind = may_break ? $urandom_range(0, 5) : 5;
        if (hold > 0) hold_left = hold;
        for (i = 0; i < pulls; i++) begin
            if (i == event_at) begin
                case (event_kind)
                    0: send_op(FUNC_LOAD, $urandom, $urandom, $urandom);
                    1: begin
                        // shrink or grow the column count mid-stream
                        drain();
                        write_reg(CFG_NUM_COLS, $urandom_range(0, ceff + 3));
                    end
                    2: send_op(FUNC_RESTART, $urandom, $urandom, $urandom);
                    default: ;
                endcase
            end
            send_op(FUNC_PULL, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin : stimulus
        int ph, goal, cols, rows, roll;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner indexes and values at reset sizes
        send_op(FUNC_LOAD, 10'd1023, 10'd0, 32'hFFFF_FFFF);
        send_op(FUNC_LOAD, 10'd1023, 10'd1023, 32'h0000_0000);
        send_op(FUNC_LOAD, 10'd0, 10'd0, 32'hA5A5_5A5A);
        send_op(FUNC_LOAD, 10'd0, 10'd1023, 32'h0000_0001);
        send_op(FUNC_NONE, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
        pull_n(4);
        send_op(FUNC_LOAD, 10'd0, 10'd1, 32'h1234_5678);   // too late, dropped
        pull_n(1);
        drain();
        write_reg(CFG_IDX_TOP, 11'h7FF);
        write_reg(CFG_NUM_COLS, 11'd2);
        write_reg(CFG_NUM_ROWS, 11'd3);
        send_op(FUNC_RESTART, 10'd0, 10'd0, 32'd0);
        send_op(FUNC_LOAD, 10'd2, 10'd1, 32'hDEAD_BEEF);
        send_op(FUNC_LOAD, 10'd3, 10'd0, 32'h0BAD_0BAD);   // row out of range
        send_op(FUNC_LOAD, 10'd0, 10'd2, 32'h0BAD_0BAD);   // column out of range
        send_op(FUNC_LOAD, 10'd0, 10'd0, 32'hCAFE_F00D);
        pull_n(7);                                        // two past the end

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            if (ph == 0) begin
                fill_store();
                run_session(2047, 2047, 25, 1'b0, 0);
                run_session(1024, 1024, 10, 1'b0, 0);
                run_session(0, 5, 4, 1'b0, 0);
                run_session(1, 0, 4, 1'b0, 0);
                run_session(4, 16, 12, 1'b0, HOLD_CYCLES);
                run_session(1, 1, 3, 1'b0, 0);
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                roll = $urandom_range(99);
                if (roll < 70)      cols = $urandom_range(1, 12);
                else if (roll < 90) cols = $urandom_range(13, 64);
                else                cols = $urandom_range(0, 3);
                roll = $urandom_range(99);
                if (roll < 40)      rows = $urandom_range(1, 32);
                else if (roll < 80) rows = MAX_ROWS;
                else                rows = $urandom_range(1, MAX_ROWS);
                run_session(cols, rows, $urandom_range(0, 30), 1'b1, 0);
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
design/sct_pkg.sv
design/sct_ctrl.sv
design/sct_datapath.sv
design/sparse_csr_transpose_core.sv
dv/sct_checker.sv
dv/tb_sparse_csr_transpose_core.sv
